/* rtl/weighted_instruction_cost_profiler_macros.svh */
// assertion macros shared by the profiler modules
`ifndef WEIGHTED_INSTRUCTION_COST_PROFILER_MACROS_SVH
`define WEIGHTED_INSTRUCTION_COST_PROFILER_MACROS_SVH

// same-cycle implication
`define WICP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wicp assertion failed");

// next-cycle implication
`define WICP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wicp assertion failed");

`endif

/* rtl/wicp_pkg.sv */
package wicp_pkg;

    localparam int SLOT_COUNT_DEF  = 64;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int SLOT_IDX_W      = 8;
    localparam int ENTRY_W         = 128;

    localparam logic [1:0] CMD_RETIRE = 2'd0;
    localparam logic [1:0] CMD_MARK   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [2:0] OP_RETIRE    = 3'd0;
    localparam logic [2:0] OP_READ      = 3'd1;
    localparam logic [2:0] OP_READ_NONE = 3'd2;
    localparam logic [2:0] OP_START     = 3'd3;
    localparam logic [2:0] OP_END       = 3'd4;
    localparam logic [2:0] OP_CLEAR     = 3'd5;
    localparam logic [2:0] OP_NOP       = 3'd6;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        instr_word;
        logic               is_a32;
        logic signed [31:0] mark_value;
        logic [5:0]         read_slot;
    } request_t;

    typedef struct packed {
        logic [7:0]  instr_cost;
        logic [63:0] slot_cost_total;
        logic [63:0] slot_insn_total;
        logic [63:0] buffer_cost;
        logic        buffer_done;
        logic [63:0] buffers_ended;
    } result_t;

    typedef struct packed {
        logic [2:0]            kind;
        logic [7:0]            cost;
        logic [SLOT_IDX_W-1:0] slot;
    } op_t;

endpackage

/* rtl/weighted_instruction_cost_profiler.sv */
// instruction cost profiler
// request channel: an item is taken at a clock edge with start high and busy low;
//   command selects retire, mark, reset totals or read slot
// result channel: one item per request, shown for one cycle with result_valid high;
//   the receiver cannot stall, results are never held back waiting for it
// the front decodes the instruction cost and tracks the active slot, then
//   pushes an op into a two-entry queue; busy is high while the queue is full
// the back owns the slot store, a ram of cost and count pairs with registered read
// mark and reset-total items pass the queue entry and the result register;
//   the back takes one per cycle while no retire or read is waiting on the slot ram
// retire and in-range read items pass the queue entry, slot ram read and result register;
//   the back takes none other until done, as reads and writes share one slot ram port pair
// reset clears the queue, the buffer count, running cost and the per-slot valid bits,
//   so the slot store reads zero at once and requests are taken as soon as reset is released
module weighted_instruction_cost_profiler #(
    parameter int SLOT_COUNT  = wicp_pkg::SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = wicp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  wicp_pkg::request_t request,
    output logic               result_valid,
    output wicp_pkg::result_t  result
);

    import wicp_pkg::*;

    logic push;
    logic pop;
    logic empty;
    logic full;
    op_t  push_op;
    op_t  head;

    assign busy = full;

    wicp_front #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .full   (full),
        .push   (push),
        .op     (push_op)
    );

    wicp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .push_op(push_op),
        .pop    (pop),
        .head   (head),
        .empty  (empty),
        .full   (full)
    );

    wicp_back #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .result_valid(result_valid),
        .result      (result)
    );

endmodule

/* rtl/wicp_ram.sv */
module wicp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/wicp_front.sv */
module wicp_front #(
    parameter int SLOT_COUNT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  wicp_pkg::request_t request,
    input  logic               full,
    output logic               push,
    output wicp_pkg::op_t      op
);

    import wicp_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);

    logic [SLOT_W-1:0] active_slot_reg;
    logic [SLOT_W-1:0] active_slot_next;

    function automatic logic [7:0] fp_arith_cost(input logic [31:0] w);
        logic [3:0] opc;
        logic       dbl;
        logic [7:0] c;
        opc = {w[23], 1'b0, w[21:20]};
        dbl = w[8];
        c   = 8'd1;
        case (opc)
            4'h0, 4'h1, 4'h9, 4'hA: c = dbl ? 8'd3 : 8'd1;
            4'h2:                   c = dbl ? 8'd2 : 8'd1;
            4'h8:                   c = dbl ? 8'd29 : 8'd14;
            4'hB:
            begin
                if (w[19:16] == 4'h1 && w[7:6] == 2'b11)
                begin
                    c = dbl ? 8'd29 : 8'd14;
                end
            end
            default:                c = 8'd1;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] word_cost(input logic [31:0] w);
        logic [7:0] c;
        c = 8'd1;
        if (w[31:28] == 4'hF)
        begin
            if ((w & 32'hFE000000) == 32'hF2000000)
            begin
                c = w[6] ? 8'd2 : 8'd1;
            end
            else if ((w & 32'hFF100000) == 32'hF4000000)
            begin
                c = 8'd2;
            end
        end
        else if ((w & 32'h0F000E00) == 32'h0E000A00)
        begin
            if (w[4])
            begin
                c = ((w & 32'h00F00F10) == 32'h00F00A10 && w[20]) ? 8'd3 : 8'd2;
            end
            else
            begin
                c = fp_arith_cost(w);
            end
        end
        else if ((w & 32'h0E000E00) == 32'h0C000A00)
        begin
            if ((w & 32'h0FE00000) == 32'h0C400000)
            begin
                c = 8'd2;
            end
            else if (w[24] && !w[21])
            begin
                c = 8'd1;
            end
            else
            begin
                c = {1'b0, w[7:1]} + 8'd1;
            end
        end
        else if (w[27:25] == 3'b000 && (w & 32'h0F0000F0) == 32'h00000090)
        begin
            c = w[23] ? 8'd2 : 8'd1;
        end
        else if ((w & 32'h0FD000F0) == 32'h07100010)
        begin
            c = 8'd10;
        end
        return c;
    endfunction

    assign push = start && !full;

    always_comb
    begin
        op               = '0;
        op.kind          = OP_NOP;
        active_slot_next = active_slot_reg;
        case (request.command)
            CMD_RETIRE:
            begin
                op.kind = OP_RETIRE;
                op.cost = request.is_a32 ? word_cost(request.instr_word) : 8'd1;
                op.slot = SLOT_IDX_W'(active_slot_reg);
            end
            CMD_MARK:
            begin
                active_slot_next = '0;
                if (request.mark_value == -32'sd2)
                begin
                    op.kind = OP_START;
                end
                else if (request.mark_value == -32'sd1)
                begin
                    op.kind = OP_END;
                end
                else if ($unsigned(request.mark_value) < 32'(SLOT_COUNT))
                begin
                    active_slot_next = SLOT_W'($unsigned(request.mark_value));
                end
            end
            CMD_CLEAR:
            begin
                op.kind = OP_CLEAR;
            end
            CMD_READ:
            begin
                op.slot = SLOT_IDX_W'(request.read_slot);
                if ({26'b0, request.read_slot} < 32'(SLOT_COUNT))
                begin
                    op.kind = OP_READ;
                end
                else
                begin
                    op.kind = OP_READ_NONE;
                end
            end
            default:
            begin
                op.kind = OP_NOP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slot_reg <= '0;
        end
        else if (push)
        begin
            active_slot_reg <= active_slot_next;
        end
    end

endmodule

/* rtl/wicp_queue.sv */
module wicp_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  wicp_pkg::op_t push_op,
    input  logic          pop,
    output wicp_pkg::op_t head,
    output logic          empty,
    output logic          full
);

    import wicp_pkg::*;

    `include "weighted_instruction_cost_profiler_macros.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    `WICP_ASSERT_IMPLY(a_pop_not_empty, clk, rst_n, pop, count_reg != '0)
    `WICP_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

/* rtl/wicp_back.sv */
module wicp_back #(
    parameter int SLOT_COUNT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wicp_pkg::op_t     head,
    input  logic              empty,
    output logic              pop,
    output logic              result_valid,
    output wicp_pkg::result_t result
);

    import wicp_pkg::*;

    `include "weighted_instruction_cost_profiler_macros.svh"

    localparam int SLOT_W = $clog2(SLOT_COUNT);

    localparam logic PH_IDLE = 1'b0;
    localparam logic PH_WAIT = 1'b1;

    logic                  phase_reg;
    logic                  phase_next;
    op_t                   op_reg;
    op_t                   op_next;
    logic                  hit_reg;
    logic                  hit_next;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] valid_next;
    logic [63:0]           running_cost_reg;
    logic [63:0]           running_cost_next;
    logic [63:0]           start_cost_reg;
    logic [63:0]           start_cost_next;
    logic [63:0]           tally_reg;
    logic [63:0]           tally_next;
    result_t               result_reg;
    result_t               result_next;
    logic                  result_valid_reg;
    logic                  result_valid_next;

    logic                  ram_we;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [SLOT_W-1:0]     rd_idx;
    logic [SLOT_W-1:0]     wr_idx;
    logic [63:0]           cost_total;
    logic [63:0]           insn_total;

    assign pop    = (phase_reg == PH_IDLE) && !empty;
    assign rd_idx = head.slot[SLOT_W-1:0];
    assign wr_idx = op_reg.slot[SLOT_W-1:0];

    assign cost_total = hit_reg ? ram_rdata[ENTRY_W-1:64] : 64'd0;
    assign insn_total = hit_reg ? ram_rdata[63:0] : 64'd0;

    wicp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_idx),
        .wdata(ram_wdata),
        .re   (pop),
        .raddr(rd_idx),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        phase_next        = phase_reg;
        op_next           = op_reg;
        hit_next          = hit_reg;
        valid_next        = valid_reg;
        running_cost_next = running_cost_reg;
        start_cost_next   = start_cost_reg;
        tally_next        = tally_reg;
        result_next       = '0;
        result_next.buffers_ended = tally_reg;
        result_valid_next = 1'b0;
        ram_we            = 1'b0;
        ram_wdata         = {cost_total + 64'(op_reg.cost), insn_total + 64'd1};

        if (pop)
        begin
            case (head.kind)
                OP_RETIRE, OP_READ:
                begin
                    phase_next = PH_WAIT;
                    op_next    = head;
                    hit_next   = valid_reg[rd_idx];
                end
                OP_START:
                begin
                    start_cost_next   = running_cost_reg;
                    result_valid_next = 1'b1;
                end
                OP_END:
                begin
                    tally_next                = tally_reg + 64'd1;
                    result_next.buffer_cost   = running_cost_reg - start_cost_reg;
                    result_next.buffer_done   = 1'b1;
                    result_next.buffers_ended = tally_reg + 64'd1;
                    result_valid_next         = 1'b1;
                end
                OP_CLEAR:
                begin
                    valid_next                = '0;
                    tally_next                = '0;
                    result_next.buffers_ended = '0;
                    result_valid_next         = 1'b1;
                end
                default:
                begin
                    result_valid_next = 1'b1;
                end
            endcase
        end
        else if (phase_reg == PH_WAIT)
        begin
            phase_next        = PH_IDLE;
            result_valid_next = 1'b1;
            if (op_reg.kind == OP_RETIRE)
            begin
                ram_we                 = 1'b1;
                valid_next[wr_idx]     = 1'b1;
                running_cost_next      = running_cost_reg + 64'(op_reg.cost);
                result_next.instr_cost = op_reg.cost;
            end
            else
            begin
                result_next.slot_cost_total = cost_total;
                result_next.slot_insn_total = insn_total;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        hit_reg    <= hit_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            valid_reg        <= '0;
            running_cost_reg <= '0;
            start_cost_reg   <= '0;
            tally_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            valid_reg        <= valid_next;
            running_cost_reg <= running_cost_next;
            start_cost_reg   <= start_cost_next;
            tally_reg        <= tally_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `WICP_ASSERT_IMPLY(a_no_pop_in_wait, clk, rst_n, phase_reg == PH_WAIT, !pop)
    `WICP_ASSERT_NEXT(a_wait_gives_result, clk, rst_n, phase_reg == PH_WAIT, (phase_reg == PH_IDLE) && result_valid_reg)
    `WICP_ASSERT_NEXT(a_clear_drops_slots, clk, rst_n, pop && (head.kind == OP_CLEAR), (valid_reg == '0) && (tally_reg == '0))

endmodule
